// File: design/boot_tag_list_ram_summarizer_macros.svh
`ifndef BOOT_TAG_LIST_RAM_SUMMARIZER_MACROS_SVH
`define BOOT_TAG_LIST_RAM_SUMMARIZER_MACROS_SVH

// same-cycle implication, reset masked
`define BTLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define BTLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/btls_pkg.sv
package btls_pkg;

  localparam logic [31:0] MagicConst = 32'h36D7_6289;
  localparam int unsigned MaxModules = 8;

  // tag type codes
  localparam logic [31:0] TagEnd    = 32'd0;
  localparam logic [31:0] TagModule = 32'd3;
  localparam logic [31:0] TagBasic  = 32'd4;
  localparam logic [31:0] TagMmap   = 32'd6;
  localparam logic [31:0] TagEfi    = 32'd17;

  // byte offsets inside a tag
  localparam logic [31:0] OffType   = 32'd0;
  localparam logic [31:0] OffSize   = 32'd4;
  localparam logic [31:0] OffFirst  = 32'd8;
  localparam logic [31:0] OffSecond = 32'd12;
  localparam logic [31:0] OffEntry  = 32'd16;

  // map entry layout
  localparam logic [32:0] MapEntryMin  = 33'd24;
  localparam logic [32:0] EfiEntryMin  = 33'd32;
  localparam logic [31:0] MapRelLenLo  = 32'd8;
  localparam logic [31:0] MapRelLenHi  = 32'd12;
  localparam logic [31:0] MapRelType   = 32'd16;
  localparam logic [31:0] EfiRelType   = 32'd0;
  localparam logic [31:0] EfiRelPgLo   = 32'd24;
  localparam logic [31:0] EfiRelPgHi   = 32'd28;
  localparam logic [31:0] MapAvailable = 32'd1;

  // EFI descriptor types counted as RAM
  localparam logic [31:0] EfiLoaderCode   = 32'd1;
  localparam logic [31:0] EfiLoaderData   = 32'd2;
  localparam logic [31:0] EfiBootCode     = 32'd3;
  localparam logic [31:0] EfiBootData     = 32'd4;
  localparam logic [31:0] EfiConventional = 32'd7;

  localparam logic RecModule  = 1'b0;
  localparam logic RecSummary = 1'b1;

  typedef enum logic [2:0] {
    KIND_OTHER,
    KIND_BASIC,
    KIND_MAP,
    KIND_EFI,
    KIND_MODULE
  } tag_kind_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_MAP,
    SRC_EFI,
    SRC_BASIC
  } ram_src_e;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
  } item_t;

  typedef struct packed {
    logic        rec_kind;
    logic [31:0] mod_base;
    logic [31:0] mod_end;
    logic [2:0]  mod_index;
    logic [63:0] ram_total;
    ram_src_e    ram_src;
    logic [3:0]  mod_count;
    logic        magic_valid;
  } res_t;

  // tag size rounded up to 8 bytes, never below 8
  function automatic logic [31:0] pad8(input logic [31:0] len);
    logic [31:0] p;
    p = (len + 32'd7) & ~32'd7;
    return (p < 32'd8) ? 32'd8 : p;
  endfunction

endpackage

// File: design/btls_in_stage.sv
module btls_in_stage import btls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t item_i,
  input  logic  adv_i,
  output logic  in_stall_o,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_stall_o   = valid_q && !adv_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

endmodule

// File: design/btls_walker.sv
`include "boot_tag_list_ram_summarizer_macros.svh"

module btls_walker import btls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  logic  magic_ok_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  logic        active_q, active_d;
  logic        hdr_q, hdr_d;
  tag_kind_e   kind_q, kind_d;
  logic [31:0] tag_len_q, tag_len_d;
  logic [31:0] tbo_q, tbo_d;
  logic [31:0] stride_q, stride_d;
  logic [31:0] ebo_q, ebo_d;
  logic [31:0] held_lo_q, held_lo_d;
  logic [63:0] held_len_q, held_len_d;
  logic        type_ok_q, type_ok_d;
  logic [63:0] map_sum_q, map_sum_d;
  logic [63:0] efi_sum_q, efi_sum_d;
  logic [63:0] basic_q, basic_d;
  logic [3:0]  seen_q, seen_d;

  logic [32:0] ent_min;
  logic        stride_ok;
  logic [32:0] ebo_sum;
  logic [31:0] ebo_n;
  logic        fit;
  logic        in_ent;
  logic [31:0] rel;
  logic [31:0] nxt;
  logic [63:0] new_len;
  logic [32:0] basic_sum;

  // entry tracking for map walks
  always_comb begin
    ent_min   = (kind_q == KIND_EFI) ? EfiEntryMin : MapEntryMin;
    stride_ok = {1'b0, stride_q} >= ent_min;
    ebo_sum   = {1'b0, ebo_q} + {1'b0, stride_q};
    ebo_n     = ({1'b0, tbo_q} >= ebo_sum) ? ebo_sum[31:0] : ebo_q;
    fit       = ({1'b0, ebo_n} + ent_min) <= {1'b0, tag_len_q};
    in_ent    = tbo_q >= ebo_n;
    rel       = tbo_q - ebo_n;
    new_len   = {item_i.word, held_lo_q};
    basic_sum = {1'b0, held_lo_q} + {1'b0, item_i.word};
    nxt       = tbo_q + 32'd4;
  end

  always_comb begin
    active_d    = active_q;
    hdr_d       = hdr_q;
    kind_d      = kind_q;
    tag_len_d   = tag_len_q;
    tbo_d       = tbo_q;
    stride_d    = stride_q;
    ebo_d       = ebo_q;
    held_lo_d   = held_lo_q;
    held_len_d  = held_len_q;
    type_ok_d   = type_ok_q;
    map_sum_d   = map_sum_q;
    efi_sum_d   = efi_sum_q;
    basic_d     = basic_q;
    seen_d      = seen_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (item_i.first) begin
      active_d   = 1'b1;
      hdr_d      = 1'b1;
      kind_d     = KIND_OTHER;
      tag_len_d  = '0;
      tbo_d      = '0;
      stride_d   = '0;
      ebo_d      = '0;
      held_lo_d  = '0;
      held_len_d = '0;
      type_ok_d  = 1'b0;
      map_sum_d  = '0;
      efi_sum_d  = '0;
      basic_d    = '0;
      seen_d     = '0;
    end else if (active_q) begin
      if (hdr_q) begin
        hdr_d = 1'b0;
      end else if (tbo_q == OffType) begin
        if (item_i.word == TagEnd) begin
          res_valid_o    = 1'b1;
          res_o.rec_kind = RecSummary;
          if (magic_ok_i) begin
            if (map_sum_q != '0) begin
              res_o.ram_total = map_sum_q;
              res_o.ram_src   = SRC_MAP;
            end else if (efi_sum_q != '0) begin
              res_o.ram_total = efi_sum_q;
              res_o.ram_src   = SRC_EFI;
            end else if (basic_q != '0) begin
              res_o.ram_total = basic_q;
              res_o.ram_src   = SRC_BASIC;
            end
            res_o.mod_count   = seen_q;
            res_o.magic_valid = 1'b1;
          end
          active_d = 1'b0;
          tbo_d    = '0;
        end else begin
          case (item_i.word)
            TagBasic: kind_d = KIND_BASIC;
            TagMmap: begin
              kind_d    = KIND_MAP;
              map_sum_d = '0;
            end
            TagEfi: begin
              kind_d    = KIND_EFI;
              efi_sum_d = '0;
            end
            TagModule: kind_d = KIND_MODULE;
            default: kind_d = KIND_OTHER;
          endcase
          tbo_d = OffSize;
        end
      end else begin
        case (tbo_q)
          OffSize: tag_len_d = item_i.word;
          OffFirst: begin
            if (kind_q == KIND_BASIC || kind_q == KIND_MODULE) begin
              held_lo_d = item_i.word;
            end else if (kind_q == KIND_MAP || kind_q == KIND_EFI) begin
              stride_d = item_i.word & ~32'd3;
              ebo_d    = OffEntry;
            end
          end
          OffSecond: begin
            if (kind_q == KIND_BASIC) begin
              basic_d = {21'd0, basic_sum, 10'd0};
            end else if (kind_q == KIND_MODULE && magic_ok_i &&
                         seen_q < 4'(MaxModules)) begin
              res_valid_o       = 1'b1;
              res_o.rec_kind    = RecModule;
              res_o.mod_base    = held_lo_q;
              res_o.mod_end     = item_i.word;
              res_o.mod_index   = seen_q[2:0];
              res_o.magic_valid = 1'b1;
              seen_d            = seen_q + 4'd1;
            end
          end
          default: begin
            if ((kind_q == KIND_MAP || kind_q == KIND_EFI) && stride_ok) begin
              ebo_d = ebo_n;
              if (fit && in_ent) begin
                if (kind_q == KIND_MAP) begin
                  if (rel == MapRelLenLo) begin
                    held_lo_d = item_i.word;
                  end else if (rel == MapRelLenHi) begin
                    held_len_d = new_len;
                  end else if (rel == MapRelType && item_i.word == MapAvailable) begin
                    map_sum_d = map_sum_q + held_len_q;
                  end
                end else begin
                  if (rel == EfiRelType) begin
                    type_ok_d = item_i.word == EfiLoaderCode ||
                                item_i.word == EfiLoaderData ||
                                item_i.word == EfiBootCode ||
                                item_i.word == EfiBootData ||
                                item_i.word == EfiConventional;
                  end else if (rel == EfiRelPgLo) begin
                    held_lo_d = item_i.word;
                  end else if (rel == EfiRelPgHi) begin
                    held_len_d = new_len;
                    if (type_ok_q) begin
                      efi_sum_d = efi_sum_q + {new_len[51:0], 12'd0};
                    end
                  end
                end
              end
            end
          end
        endcase
        tbo_d = (nxt >= pad8(tag_len_d)) ? '0 : nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      hdr_q      <= 1'b0;
      kind_q     <= KIND_OTHER;
      tag_len_q  <= '0;
      tbo_q      <= '0;
      stride_q   <= '0;
      ebo_q      <= '0;
      held_lo_q  <= '0;
      held_len_q <= '0;
      type_ok_q  <= 1'b0;
      map_sum_q  <= '0;
      efi_sum_q  <= '0;
      basic_q    <= '0;
      seen_q     <= '0;
    end else if (fire_i) begin
      active_q   <= active_d;
      hdr_q      <= hdr_d;
      kind_q     <= kind_d;
      tag_len_q  <= tag_len_d;
      tbo_q      <= tbo_d;
      stride_q   <= stride_d;
      ebo_q      <= ebo_d;
      held_lo_q  <= held_lo_d;
      held_len_q <= held_len_d;
      type_ok_q  <= type_ok_d;
      map_sum_q  <= map_sum_d;
      efi_sum_q  <= efi_sum_d;
      basic_q    <= basic_d;
      seen_q     <= seen_d;
    end
  end

  `BTLS_ASSERT_NEXT(a_summary_ends_walk, fire_i && res_valid_o && res_o.rec_kind == RecSummary, !active_q, "walk still active after summary")
  `BTLS_ASSERT_NOW(a_module_rec_legal, res_valid_o && res_o.rec_kind == RecModule, magic_ok_i && seen_q < 4'(MaxModules), "module record without magic or slot")
  `BTLS_ASSERT_NEXT(a_first_restarts, fire_i && item_i.first, active_q && hdr_q && seen_q == '0, "first word did not restart walk")

endmodule

// File: design/btls_out_stage.sv
module btls_out_stage import btls_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic ld_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic ready_o,
  output logic out_valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= ld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ld_i) begin
      res_q <= res_i;
    end
  end

endmodule

// File: design/boot_tag_list_ram_summarizer.sv
// Channel   Handshake                  Payload
// in        in_valid_i / in_stall_o    word_i, first_word_i
// out       out_valid_o / out_stall_i  record_kind_o .. magic_valid_o
// cfg       cfg_valid_i / cfg_ready_o  cfg_boot_magic_i
//
// One word per cycle sustained while no held result stalls the walker; a result is registered in the result register.
// Rate is set by the input register feeding the walker and the result register.
// Asynchronous active-low reset clears the walk and sets boot_magic to zero.
// A held result stalls the walker, which then stalls the input register.
module boot_tag_list_ram_summarizer import btls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_boot_magic_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  input  logic        first_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic [31:0] module_start_o,
  output logic [31:0] module_end_o,
  output logic [2:0]  module_index_o,
  output logic [63:0] ram_bytes_o,
  output logic [1:0]  ram_src_o,
  output logic [3:0]  modules_kept_o,
  output logic        magic_valid_o
);

  logic [31:0] magic_q;
  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        out_ready;
  logic        fire;
  logic        res_valid;
  res_t        res;
  res_t        out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      magic_q <= cfg_boot_magic_i;
    end
  end

  assign in_item.word  = word_i;
  assign in_item.first = first_word_i;

  btls_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .item_i      (in_item),
    .adv_i       (out_ready),
    .in_stall_o  (in_stall_o),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  assign fire = item_valid && out_ready;

  btls_walker u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item),
    .magic_ok_i (magic_q == MagicConst),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  btls_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_i       (fire && res_valid),
    .res_i      (res),
    .out_stall_i(out_stall_i),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .res_o      (out_res)
  );

  assign record_kind_o  = out_res.rec_kind;
  assign module_start_o = out_res.mod_base;
  assign module_end_o   = out_res.mod_end;
  assign module_index_o = out_res.mod_index;
  assign ram_bytes_o    = out_res.ram_total;
  assign ram_src_o      = out_res.ram_src;
  assign modules_kept_o = out_res.mod_count;
  assign magic_valid_o  = out_res.magic_valid;

endmodule
